// ===== rtl/core/tvm_pkg.sv =====
`default_nettype none

package tvm_pkg;

   // request kinds
   localparam logic [2:0] REQ_EXEC    = 3'd0;
   localparam logic [2:0] REQ_REPLY   = 3'd1;
   localparam logic [2:0] REQ_RESTART = 3'd2;
   localparam logic [2:0] REQ_WRITE   = 3'd3;
   localparam logic [2:0] REQ_READ    = 3'd4;

   // opcodes, header bits 7..5
   localparam logic [2:0] OP_LOAD  = 3'd0;
   localparam logic [2:0] OP_STORE = 3'd1;
   localparam logic [2:0] OP_JUMP  = 3'd2;
   localparam logic [2:0] OP_IMM   = 3'd3;
   localparam logic [2:0] OP_ADD   = 3'd4;
   localparam logic [2:0] OP_LOGIC = 3'd5;
   localparam logic [2:0] OP_SHIFT = 3'd6;
   localparam logic [2:0] OP_EXTRA = 3'd7;

   localparam logic [4:0] REG_ACC = 5'd0;
   localparam int unsigned NUM_REGS = 32;

   typedef struct packed {
      logic [2:0]  req_type;
      logic [7:0]  instr_header;
      logic [7:0]  instr_byte1;
      logic [7:0]  instr_byte2;
      logic [7:0]  start_address;
      logic [4:0]  reg_index;
      logic [31:0] data_value;
   } tvm_req_type;

   typedef struct packed {
      logic [7:0]  next_pc;
      logic        halted;
      logic        call_request;
      logic [31:0] call_id;
      logic [31:0] call_arg;
      logic [31:0] read_value;
   } tvm_rsp_type;

   typedef struct packed {
      logic [7:0] pc;
      logic       halt;
      logic       wait_reply;
      logic [3:0] dest;
   } tvm_state_type;

   typedef struct packed {
      logic        en;
      logic [4:0]  addr;
      logic [31:0] data;
   } tvm_wr_type;

   function automatic logic [7:0] op_len(input logic [2:0] op);
      logic [7:0] len;
      unique case (op)
         OP_LOAD, OP_STORE, OP_EXTRA: len = 8'd1;
         default:                     len = 8'd2;
      endcase
      return len;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/tiny_register_vm_core_unit.sv =====
// the read stage registers the item and operands, execute registers the result
// throughput: one item per cycle unless the output stalls; both register operands come
// from two register file copies, each with one synchronous read port, read at acceptance
// a write in the execute cycle is forwarded to a read issued at the same edge
// reset: pc, halt and pending call clear, proc_present sets, per-register valid
// bits clear so every register reads zero until written; no clearing pass
`default_nettype none

module tiny_register_vm_core_unit (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  tvm_pkg::tvm_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output tvm_pkg::tvm_rsp_type rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic                 csr_data
);
   import tvm_pkg::*;

   logic [31:0] rf_a_mem [NUM_REGS];
   logic [31:0] rf_b_mem [NUM_REGS];

   logic [NUM_REGS-1:0] vld_ff;
   logic [NUM_REGS-1:0] vld_in;

   logic          proc_present_ff;
   tvm_state_type st_ff;
   tvm_state_type st_in;
   logic          ex_valid_ff;
   tvm_req_type   ex_item_ff;
   logic          rsp_valid_ff;
   tvm_rsp_type   rsp_data_ff;

   logic [31:0] rd_a_ff;
   logic [31:0] rd_b_ff;
   logic        vld_a_ff;
   logic        vld_b_ff;
   logic        hit_a_ff;
   logic        hit_b_ff;
   logic [31:0] fwd_ff;

   logic [4:0]    raddr_a;
   logic [4:0]    raddr_b;
   logic          req_acc;
   logic          ex_adv;
   logic [31:0]   ra;
   logic [31:0]   rb;
   logic          wr_now;
   tvm_wr_type    wr;
   tvm_rsp_type   rsp_in;
   tvm_state_type rsp_st_next;

   assign ex_adv    = ex_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !ex_valid_ff || ex_adv;
   assign req_acc   = req_valid && req_ready;
   assign wr_now    = ex_adv && wr.en;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // operand addresses straight from the incoming item
   always_comb begin
      raddr_a = REG_ACC;
      raddr_b = REG_ACC;
      unique case (req_data.req_type)
         REQ_EXEC: begin
            unique case (req_data.instr_header[7:5])
               OP_LOAD: raddr_a = req_data.instr_header[4:0];
               OP_JUMP: raddr_b = {1'b0, req_data.instr_header[3:0]};
               OP_ADD, OP_LOGIC, OP_SHIFT: begin
                  raddr_a = {1'b0, req_data.instr_byte1[7:4]};
                  raddr_b = {1'b0, req_data.instr_byte1[3:0]};
               end
               OP_EXTRA: begin
                  if (!req_data.instr_header[4]) begin
                     raddr_a = {1'b0, req_data.instr_byte2[7:4]};
                     raddr_b = {1'b0, req_data.instr_byte2[3:0]};
                  end else begin
                     raddr_a = {1'b0, req_data.instr_header[0], req_data.instr_byte1[7:5]};
                  end
               end
               default: begin
               end
            endcase
         end
         REQ_READ: raddr_a = req_data.reg_index;
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_now) begin
         rf_a_mem[wr.addr] <= wr.data;
         rf_b_mem[wr.addr] <= wr.data;
      end
      if (req_acc) begin
         rd_a_ff <= rf_a_mem[raddr_a];
         rd_b_ff <= rf_b_mem[raddr_b];
      end
   end

   always_comb begin
      vld_in = vld_ff;
      if (wr_now) begin
         vld_in[wr.addr] = 1'b1;
      end
   end

   // operand select: forwarded write, stored value, or zero if never written
   assign ra = hit_a_ff ? fwd_ff : (vld_a_ff ? rd_a_ff : '0);
   assign rb = hit_b_ff ? fwd_ff : (vld_b_ff ? rd_b_ff : '0);

   tvm_exec u_tvm_exec (
      .item         (ex_item_ff),
      .ra           (ra),
      .rb           (rb),
      .st           (st_ff),
      .proc_present (proc_present_ff),
      .st_next      (rsp_st_next),
      .wr           (wr),
      .rsp          (rsp_in)
   );

   always_comb begin
      st_in = st_ff;
      if (ex_adv) begin
         st_in = rsp_st_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff          <= '0;
         proc_present_ff <= 1'b1;
         st_ff           <= '0;
         ex_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         vld_ff <= vld_in;
         st_ff  <= st_in;
         if (csr_valid && csr_ready) begin
            proc_present_ff <= csr_data;
         end
         if (req_ready) begin
            ex_valid_ff <= req_valid;
         end
         if (ex_adv) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         ex_item_ff <= req_data;
         vld_a_ff   <= vld_ff[raddr_a];
         vld_b_ff   <= vld_ff[raddr_b];
         hit_a_ff   <= wr_now && (wr.addr == raddr_a);
         hit_b_ff   <= wr_now && (wr.addr == raddr_b);
         fwd_ff     <= wr.data;
      end
      if (ex_adv) begin
         rsp_data_ff <= rsp_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/tvm_exec.sv =====
`default_nettype none

module tvm_exec (
   input  tvm_pkg::tvm_req_type   item,
   input  logic [31:0]            ra,
   input  logic [31:0]            rb,
   input  tvm_pkg::tvm_state_type st,
   input  logic                   proc_present,
   output tvm_pkg::tvm_state_type st_next,
   output tvm_pkg::tvm_wr_type    wr,
   output tvm_pkg::tvm_rsp_type   rsp
);
   import tvm_pkg::*;

   logic [7:0]  h;
   logic [7:0]  b1;
   logic [7:0]  b2;
   logic [2:0]  op;
   logic [3:0]  amt;
   logic [7:0]  pc_inc;
   logic [7:0]  pc_inc2;
   logic [31:0] alu_res;

   assign h       = item.instr_header;
   assign b1      = item.instr_byte1;
   assign b2      = item.instr_byte2;
   assign op      = h[7:5];
   assign amt     = b1[3:0];
   assign pc_inc  = st.pc + op_len(op);
   assign pc_inc2 = pc_inc + 8'd1;

   always_comb begin
      unique case (op)
         OP_ADD:   alu_res = h[4] ? (ra - rb) : (ra + rb);
         OP_LOGIC: alu_res = h[4] ? (ra | rb) : (ra & rb);
         OP_SHIFT: alu_res = h[4] ? (ra >> amt) : (ra << amt);
         default:  alu_res = '0;
      endcase
   end

   always_comb begin
      st_next = st;
      wr      = '0;
      rsp     = '0;
      unique case (item.req_type)
         REQ_EXEC: begin
            if (!st.halt && !st.wait_reply) begin
               st_next.pc = pc_inc;
               unique case (op)
                  OP_LOAD: begin
                     wr.en   = 1'b1;
                     wr.addr = REG_ACC;
                     wr.data = ra;
                  end
                  OP_STORE: begin
                     wr.en   = 1'b1;
                     wr.addr = h[4:0];
                     wr.data = ra;
                  end
                  OP_JUMP: begin
                     if (h[4] ? (ra < rb) : (ra == rb)) begin
                        st_next.pc = b1;
                     end
                  end
                  OP_IMM: begin
                     wr.en   = 1'b1;
                     wr.addr = REG_ACC;
                     if (h[4]) begin
                        wr.data    = {h[3:0], b1, b2, ra[11:0]};
                        st_next.pc = pc_inc2;
                     end else begin
                        wr.data = {20'd0, h[3:0], b1};
                     end
                  end
                  OP_ADD, OP_LOGIC, OP_SHIFT: begin
                     wr.en   = 1'b1;
                     wr.addr = {1'b0, h[3:0]};
                     wr.data = alu_res;
                  end
                  OP_EXTRA: begin
                     priority if (!h[4]) begin
                        // call: ra holds the id, rb the argument
                        st_next.pc = pc_inc2;
                        if (proc_present) begin
                           st_next.wait_reply = 1'b1;
                           st_next.dest       = b1[3:0];
                           rsp.call_request   = 1'b1;
                           rsp.call_id        = ra;
                           rsp.call_arg       = rb;
                        end else begin
                           wr.en   = 1'b1;
                           wr.addr = {1'b0, b1[3:0]};
                           wr.data = rb;
                        end
                     end else if (!h[3]) begin
                        wr.en   = 1'b1;
                        wr.addr = REG_ACC;
                        wr.data = {29'd0, h[2:0]};
                     end else if (!h[2]) begin
                        // pc swap, link value is the address after the instruction
                        wr.en      = 1'b1;
                        wr.addr    = {1'b0, b1[3:0]};
                        wr.data    = {24'd0, pc_inc2};
                        st_next.pc = ra[7:0];
                     end else begin
                        st_next.halt = 1'b1;
                     end
                  end
               endcase
            end
         end
         REQ_REPLY: begin
            if (st.wait_reply) begin
               wr.en              = 1'b1;
               wr.addr            = {1'b0, st.dest};
               wr.data            = item.data_value;
               st_next.wait_reply = 1'b0;
            end
         end
         REQ_RESTART: begin
            st_next.pc         = item.start_address;
            st_next.halt       = 1'b0;
            st_next.wait_reply = 1'b0;
         end
         REQ_WRITE: begin
            wr.en   = 1'b1;
            wr.addr = item.reg_index;
            wr.data = item.data_value;
         end
         REQ_READ: begin
            rsp.read_value = ra;
         end
         default: begin
         end
      endcase
      rsp.next_pc = st_next.pc;
      rsp.halted  = st_next.halt;
   end

endmodule

`default_nettype wire

// ===== rtl/core/tvm_checker.sv =====
`default_nettype none

module tvm_checker (
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 req_valid,
   input wire logic                 req_ready,
   input wire logic                 rsp_valid,
   input wire logic                 rsp_ready,
   input wire tvm_pkg::tvm_rsp_type rsp_data
);
   import tvm_pkg::*;

   logic [2:0] inflight_ff;
   logic [2:0] inflight_in;
   logic       req_acc;
   logic       rsp_acc;

   assign req_acc     = req_valid && req_ready;
   assign rsp_acc     = rsp_valid && rsp_ready;
   assign inflight_in = inflight_ff + {2'd0, req_acc} - {2'd0, rsp_acc};

   always_ff @(posedge clock) begin
      if (reset) begin
         inflight_ff <= '0;
      end else begin
         inflight_ff <= inflight_in;
      end
   end

   // a stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response dropped or changed while stalled");

   // one item executing plus one waiting at the output at most
   assert property (@(posedge clock) disable iff (reset)
      inflight_ff <= 3'd2)
      else $error("more than two items in flight");

   // no response without an accepted item behind it
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> inflight_ff != 3'd0)
      else $error("response with no item outstanding");

   // call fields carry data only on a call request, and a halted core issues none
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.call_request |-> rsp_data.call_id == '0 && rsp_data.call_arg == '0)
      else $error("call fields set without a call request");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.call_request |-> !rsp_data.halted && rsp_data.read_value == '0)
      else $error("call request from a halted core or on a read");

endmodule

bind tiny_register_vm_core_unit tvm_checker u_tvm_checker (.*);

`default_nettype wire

// ===== bench/tiny_register_vm_core_unit_tb.sv =====
module tiny_register_vm_core_unit_tb;
   import tvm_pkg::*;

   localparam int unsigned CYCLE_LIMIT  = 200000;
   localparam int unsigned DRAIN_CYCLES = 4;
   localparam int unsigned RANDOM_ITEMS = 650;

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   tvm_req_type req_data  = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   tvm_rsp_type rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_data  = 1'b0;

   // machine state as the bench tracks it
   logic [31:0] vm_regs [NUM_REGS];
   logic [7:0]  vm_pc;
   logic        vm_halted;
   logic        vm_waiting;
   logic [3:0]  vm_dest;
   logic        handler_present;

   tvm_rsp_type machine_results_q[$];
   tvm_rsp_type oldest_result;
   int unsigned mismatch_count     = 0;
   int unsigned cycle_count        = 0;
   int unsigned sender_idle_pct    = 0;
   int unsigned receiver_stall_pct = 0;

   tiny_register_vm_core_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // advances the tracked machine by one item and returns the result it owes
   function automatic tvm_rsp_type machine_step(input tvm_req_type item);
      tvm_rsp_type res;
      logic [7:0]  h;
      logic [7:0]  b1;
      logic [7:0]  b2;
      logic [7:0]  npc;
      logic [2:0]  op;
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] target;
      logic        alt;
      res = '0;
      h   = item.instr_header;
      b1  = item.instr_byte1;
      b2  = item.instr_byte2;
      op  = h[7:5];
      alt = h[4];
      case (item.req_type)
         REQ_EXEC: begin
            if (!vm_halted && !vm_waiting) begin
               npc = vm_pc + ((op == OP_LOAD || op == OP_STORE || op == OP_EXTRA) ? 8'd1 : 8'd2);
               case (op)
                  OP_LOAD:  vm_regs[REG_ACC] = vm_regs[h[4:0]];
                  OP_STORE: vm_regs[h[4:0]] = vm_regs[REG_ACC];
                  OP_JUMP: begin
                     b = vm_regs[h[3:0]];
                     if (alt ? (vm_regs[REG_ACC] < b) : (vm_regs[REG_ACC] == b)) npc = b1;
                  end
                  OP_IMM: begin
                     if (alt) begin
                        vm_regs[REG_ACC] = {h[3:0], b1, b2, vm_regs[REG_ACC][11:0]};
                        npc = npc + 8'd1;
                     end else begin
                        vm_regs[REG_ACC] = {20'd0, h[3:0], b1};
                     end
                  end
                  OP_ADD, OP_LOGIC, OP_SHIFT: begin
                     a = vm_regs[b1[7:4]];
                     b = vm_regs[b1[3:0]];
                     if (op == OP_ADD) begin
                        a = alt ? a - b : a + b;
                     end else if (op == OP_LOGIC) begin
                        a = alt ? (a | b) : (a & b);
                     end else begin
                        // shift amount is the operand index itself
                        a = alt ? (a >> b1[3:0]) : (a << b1[3:0]);
                     end
                     vm_regs[h[3:0]] = a;
                  end
                  OP_EXTRA: begin
                     if (!h[4]) begin
                        npc = npc + 8'd1;
                        if (handler_present) begin
                           vm_waiting       = 1'b1;
                           vm_dest          = b1[3:0];
                           res.call_request = 1'b1;
                           res.call_id      = vm_regs[b2[7:4]];
                           res.call_arg     = vm_regs[b2[3:0]];
                        end else begin
                           vm_regs[b1[3:0]] = vm_regs[b2[3:0]];
                        end
                     end else if (!h[3]) begin
                        vm_regs[REG_ACC] = {29'd0, h[2:0]};
                     end else if (!h[2]) begin
                        // pc swap reads the old target before the link write
                        target           = vm_regs[{h[0], b1[7:5]}];
                        npc              = npc + 8'd1;
                        vm_regs[b1[3:0]] = {24'd0, npc};
                        npc              = target[7:0];
                     end else begin
                        vm_halted = 1'b1;
                     end
                  end
                  default: ;
               endcase
               vm_pc = npc;
            end
         end
         REQ_REPLY: begin
            if (vm_waiting) begin
               vm_regs[vm_dest] = item.data_value;
               vm_waiting       = 1'b0;
            end
         end
         REQ_RESTART: begin
            vm_pc      = item.start_address;
            vm_halted  = 1'b0;
            vm_waiting = 1'b0;
         end
         REQ_WRITE: vm_regs[item.reg_index] = item.data_value;
         REQ_READ:  res.read_value = vm_regs[item.reg_index];
         default: ;
      endcase
      res.next_pc = vm_pc;
      res.halted  = vm_halted;
      return res;
   endfunction

   function automatic tvm_req_type noise_item(input logic [2:0] kind);
      tvm_req_type item;
      int unsigned pick;
      pick               = $urandom_range(7);
      item.req_type      = kind;
      item.instr_header  = 8'($urandom_range(255));
      item.instr_byte1   = 8'($urandom_range(255));
      item.instr_byte2   = 8'($urandom_range(255));
      item.start_address = 8'($urandom_range(255));
      item.reg_index     = 5'($urandom_range(31));
      if (pick == 0) begin
         item.data_value = 32'd0;
      end else if (pick == 1) begin
         item.data_value = 32'hFFFF_FFFF;
      end else begin
         item.data_value = $urandom;
      end
      return item;
   endfunction

   function automatic tvm_req_type exec_item(input logic [7:0] h, b1, b2);
      tvm_req_type item;
      item              = noise_item(REQ_EXEC);
      item.instr_header = h;
      item.instr_byte1  = b1;
      item.instr_byte2  = b2;
      return item;
   endfunction

   function automatic tvm_req_type data_item(input logic [2:0] kind, input logic [4:0] idx,
                                             input logic [31:0] value);
      tvm_req_type item;
      item            = noise_item(kind);
      item.reg_index  = idx;
      item.data_value = value;
      return item;
   endfunction

   function automatic void compare_field(input string field, input logic [31:0] want,
                                         input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", field, want, got);
         mismatch_count++;
      end
   endfunction

   task automatic send_item(input tvm_req_type item);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      machine_results_q.push_back(machine_step(item));
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (machine_results_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_config(input logic value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      handler_present = value;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (machine_results_q.size() == 0) begin
               $error("result item with none expected, next_pc %0h", rsp_data.next_pc);
               mismatch_count++;
            end else begin
               oldest_result = machine_results_q.pop_front();
               compare_field("next_pc", 32'(oldest_result.next_pc), 32'(rsp_data.next_pc));
               compare_field("halted", 32'(oldest_result.halted), 32'(rsp_data.halted));
               compare_field("call_request", 32'(oldest_result.call_request),
                             32'(rsp_data.call_request));
               compare_field("call_id", oldest_result.call_id, rsp_data.call_id);
               compare_field("call_arg", oldest_result.call_arg, rsp_data.call_arg);
               compare_field("read_value", oldest_result.read_value, rsp_data.read_value);
            end
         end
         rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tiny_register_vm_core_unit regression: fail");
         $finish;
      end
   end

   task automatic test_register_access();
      send_item(data_item(REQ_WRITE, 5'd31, 32'hFFFF_FFFF));
      send_item(data_item(REQ_WRITE, 5'd1, 32'd5));
      send_item(data_item(REQ_READ, 5'd31, 32'd0));
      // never written, reads zero
      send_item(data_item(REQ_READ, 5'd30, 32'hFFFF_FFFF));
   endtask

   task automatic test_instruction_set();
      send_item(exec_item({OP_LOAD, 5'd31}, 8'h00, 8'h00));
      send_item(exec_item({OP_STORE, 5'd2}, 8'hFF, 8'hFF));
      // equal compare against a copy, taken
      send_item(exec_item({OP_JUMP, 1'b0, 4'd2}, 8'hF0, 8'h00));
      // all ones is not below 5, falls through
      send_item(exec_item({OP_JUMP, 1'b1, 4'd1}, 8'h10, 8'h00));
      send_item(exec_item({OP_IMM, 1'b0, 4'hF}, 8'hFF, 8'h00));
      send_item(exec_item({OP_IMM, 1'b1, 4'hA}, 8'h5A, 8'hC3));
      send_item(exec_item({OP_ADD, 1'b0, 4'd3}, {4'd0, 4'd1}, 8'h00));
      send_item(exec_item({OP_ADD, 1'b1, 4'd4}, {4'd1, 4'd0}, 8'h00));
      send_item(exec_item({OP_LOGIC, 1'b0, 4'd5}, {4'd0, 4'd2}, 8'h00));
      send_item(exec_item({OP_LOGIC, 1'b1, 4'd6}, {4'd1, 4'd3}, 8'h00));
      send_item(exec_item({OP_SHIFT, 1'b0, 4'd7}, {4'd0, 4'hF}, 8'h00));
      send_item(exec_item({OP_SHIFT, 1'b1, 4'd8}, {4'd2, 4'd9}, 8'h00));
      send_item(exec_item({OP_EXTRA, 2'b10, 3'd7}, 8'h00, 8'h00));
      send_item(exec_item({OP_EXTRA, 3'b110, 2'b01}, {3'd0, 1'b0, 4'd9}, 8'h00));
   endtask

   task automatic test_call_handling();
      // reply with no call outstanding is dropped
      send_item(data_item(REQ_REPLY, 5'd0, 32'h0000_1234));
      send_item(exec_item({OP_EXTRA, 1'b0, 4'd0}, 8'h0B, 8'h1F));
      send_item(exec_item({OP_ADD, 1'b0, 4'd11}, 8'h11, 8'h00));
      send_item(data_item(REQ_REPLY, 5'd0, 32'hDEAD_BEEF));
      send_item(data_item(REQ_READ, 5'd11, 32'd0));
   endtask

   task automatic test_halt_and_restart();
      tvm_req_type item;
      send_item(exec_item({OP_EXTRA, 3'b111, 2'b11}, 8'h00, 8'h00));
      send_item(exec_item({OP_IMM, 1'b0, 4'h1}, 8'h22, 8'h00));
      item               = noise_item(REQ_RESTART);
      item.start_address = 8'hFF;
      send_item(item);
   endtask

   task automatic test_no_handler_call();
      wait_idle();
      write_config(1'b0);
      // argument lands in the target directly
      send_item(exec_item({OP_EXTRA, 1'b0, 4'd0}, 8'h0C, 8'hF1));
      send_item(data_item(REQ_READ, 5'd12, 32'd0));
      wait_idle();
      write_config(1'b1);
   endtask

   task automatic test_random_programs(input int unsigned count, input int unsigned idle_pct,
                                       input int unsigned stall_pct, input logic with_handler);
      tvm_req_type item;
      int unsigned done;
      int unsigned pick;
      wait_idle();
      write_config(with_handler);
      sender_idle_pct    = idle_pct;
      receiver_stall_pct = stall_pct;
      done               = 0;
      while (done < count) begin
         pick = $urandom_range(99);
         // mostly leave halt and pending calls promptly so programs keep running
         if (vm_halted && pick < 75) begin
            item = noise_item(REQ_RESTART);
         end else if (vm_waiting && pick < 65) begin
            item = noise_item(REQ_REPLY);
         end else begin
            pick = $urandom_range(99);
            if (pick < 62) begin
               item = noise_item(REQ_EXEC);
            end else if (pick < 76) begin
               item = noise_item(REQ_WRITE);
            end else if (pick < 88) begin
               item = noise_item(REQ_READ);
            end else if (pick < 93) begin
               item = noise_item(REQ_RESTART);
            end else begin
               item = noise_item(REQ_REPLY);
            end
         end
         send_item(item);
         done++;
      end
   endtask

   initial begin
      for (int i = 0; i < NUM_REGS; i++) vm_regs[i] = '0;
      vm_pc           = '0;
      vm_halted       = 1'b0;
      vm_waiting      = 1'b0;
      vm_dest         = '0;
      handler_present = 1'b1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_register_access();
      test_instruction_set();
      test_call_handling();
      test_halt_and_restart();
      test_no_handler_call();
      test_random_programs(RANDOM_ITEMS / 4, 0, 0, 1'b1);
      test_random_programs(RANDOM_ITEMS / 4, 55, 0, 1'b0);
      test_random_programs(RANDOM_ITEMS / 4, 0, 55, 1'b1);
      test_random_programs(RANDOM_ITEMS / 4, 18, 18, 1'b0);
      wait_idle();
      if (mismatch_count == 0 && machine_results_q.size() == 0) begin
         $display("tiny_register_vm_core_unit regression: pass");
      end else begin
         $display("tiny_register_vm_core_unit regression: fail");
      end
      $finish;
   end

endmodule
